/* rtl/core/byte_frequency_sorted_table_defines.svh */
// Assertion macros used by the RTL of the byte frequency table.
`ifndef BYTE_FREQUENCY_SORTED_TABLE_DEFINES_SVH
`define BYTE_FREQUENCY_SORTED_TABLE_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define BFST_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define BFST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BFST_ASSERT_IMPL(label, ante, cons)
`define BFST_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/core/bfst_pkg.sv */
package bfst_pkg;

  localparam int SYM_CNT = 256;
  localparam int CNT_W   = 32;
  localparam int SYM_W   = $clog2(SYM_CNT);
  localparam int DIST_W  = $clog2(SYM_CNT + 1);

  typedef enum logic [1:0] {
    ACT_COUNT = 2'd0,
    ACT_SORT  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

endpackage

/* rtl/core/byte_frequency_sorted_table.sv */
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_ready  | action, byte_value, rank
// out_    | output    | out_valid / out_ready| distinct_symbols, symbol, frequency,
//         |           |                      | entry_valid
//
// A count item reads the count memory, then writes the updated count. A read
// that finds no entry goes to the output register; one that looks an entry up
// reads the sorted memory, then the count memory, then loads the output. A sort
// item runs an insertion sort on one shared compare unit: each symbol is read with
// its count and compared with each sorted entry it passes, read with its count,
// plus a head write if it shifts the whole list; the output loads last, so the
// worst case grows with the square of the number of distinct symbols. Reset and
// clear zero the per-entry valid bits of the count memory at once; no clearing
// pass is needed. A waiting result holds off only the next result.
`include "byte_frequency_sorted_table_defines.svh"

module byte_frequency_sorted_table
  import bfst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_byte_value,
  input  logic [7:0]  in_rank,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [8:0]  out_distinct_symbols,
  output logic [7:0]  out_symbol,
  output logic [31:0] out_frequency,
  output logic        out_entry_valid
);

  typedef enum logic [3:0] {
    S_IDLE, S_CNT, S_A, S_B, S_C, S_D, S_E, S_W, S_R1, S_R2, S_EMIT
  } state_t;

  // Storage. Counts live in a memory whose entries are only trusted when
  // their valid bit is set, so reset and clear need no pass over the memory.
  logic [CNT_W-1:0] cnt_mem [SYM_CNT];
  logic [SYM_W-1:0] arr_mem [SYM_CNT];
  logic [SYM_W-1:0] srt_mem [SYM_CNT];

  state_t            state_r, state_nxt;
  logic [SYM_CNT-1:0] cvld_r, cvld_nxt;
  logic [DIST_W-1:0] distinct_r, distinct_nxt;
  logic              sort_done_r, sort_done_nxt;
  logic [SYM_W-1:0]  byte_r, byte_nxt;
  logic [SYM_W-1:0]  i_r, i_nxt;
  logic [SYM_W-1:0]  j_r, j_nxt;
  logic [SYM_W-1:0]  sym_r, sym_nxt;
  logic [SYM_W-1:0]  prev_r, prev_nxt;
  logic [CNT_W-1:0]  c_r, c_nxt;
  logic [DIST_W-1:0] res_dist_r, res_dist_nxt;
  logic [SYM_W-1:0]  res_sym_r, res_sym_nxt;
  logic [CNT_W-1:0]  res_freq_r, res_freq_nxt;
  logic              res_ev_r, res_ev_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [8:0]        out_dist_r, out_dist_nxt;
  logic [7:0]        out_sym_r, out_sym_nxt;
  logic [31:0]       out_freq_r, out_freq_nxt;
  logic              out_ev_r, out_ev_nxt;

  // Memory ports.
  logic [SYM_W-1:0] cnt_raddr, srt_raddr, cnt_waddr, arr_waddr, srt_waddr;
  logic [CNT_W-1:0] cnt_wdata, cnt_q, cnt_eff, cnt_inc;
  logic [SYM_W-1:0] arr_wdata, srt_wdata, arr_q, srt_q;
  logic             cnt_we, arr_we, srt_we, vld_q;
  logic             accept, last_sym;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign cnt_eff  = vld_q ? cnt_q : '0;
  assign cnt_inc  = cnt_eff + ((cnt_eff != '1) ? CNT_W'(1) : CNT_W'(0));
  assign last_sym = ((DIST_W'(i_r) + DIST_W'(1)) == distinct_r);

  always_ff @(posedge clk) begin
    cnt_q <= cnt_mem[cnt_raddr];
    vld_q <= cvld_r[cnt_raddr];
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
  end

  always_ff @(posedge clk) begin
    arr_q <= arr_mem[i_r];
    if (arr_we) begin
      arr_mem[arr_waddr] <= arr_wdata;
    end
  end

  always_ff @(posedge clk) begin
    srt_q <= srt_mem[srt_raddr];
    if (srt_we) begin
      srt_mem[srt_waddr] <= srt_wdata;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cvld_nxt      = cvld_r;
    distinct_nxt  = distinct_r;
    sort_done_nxt = sort_done_r;
    byte_nxt      = byte_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    sym_nxt       = sym_r;
    prev_nxt      = prev_r;
    c_nxt         = c_r;
    res_dist_nxt  = res_dist_r;
    res_sym_nxt   = res_sym_r;
    res_freq_nxt  = res_freq_r;
    res_ev_nxt    = res_ev_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_dist_nxt  = out_dist_r;
    out_sym_nxt   = out_sym_r;
    out_freq_nxt  = out_freq_r;
    out_ev_nxt    = out_ev_r;
    cnt_raddr     = byte_r;
    srt_raddr     = '0;
    cnt_we        = 1'b0;
    cnt_waddr     = byte_r;
    cnt_wdata     = cnt_inc;
    arr_we        = 1'b0;
    arr_waddr     = distinct_r[SYM_W-1:0];
    arr_wdata     = byte_r;
    srt_we        = 1'b0;
    srt_waddr     = j_r;
    srt_wdata     = sym_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_dist_nxt = distinct_r;
          res_sym_nxt  = '0;
          res_freq_nxt = '0;
          res_ev_nxt   = 1'b0;
          case (action_t'(in_action))
            ACT_COUNT: begin
              sort_done_nxt = 1'b0;
              if (9'(in_byte_value) < 9'(SYM_CNT)) begin
                byte_nxt  = in_byte_value[SYM_W-1:0];
                cnt_raddr = in_byte_value[SYM_W-1:0];
                state_nxt = S_CNT;
              end
            end
            ACT_SORT: begin
              i_nxt = '0;
              if (distinct_r == '0) begin
                sort_done_nxt = 1'b1;
                state_nxt     = S_EMIT;
              end else begin
                state_nxt = S_A;
              end
            end
            ACT_READ: begin
              if (sort_done_r && (9'(in_rank) < 9'(distinct_r))) begin
                srt_raddr = in_rank[SYM_W-1:0];
                state_nxt = S_R1;
              end else begin
                state_nxt = S_EMIT;
              end
            end
            ACT_CLEAR: begin
              cvld_nxt      = '0;
              distinct_nxt  = '0;
              sort_done_nxt = 1'b0;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_CNT: begin
        if ((cnt_eff == '0) && (distinct_r < DIST_W'(SYM_CNT))) begin
          arr_we       = 1'b1;
          distinct_nxt = distinct_r + DIST_W'(1);
        end
        cnt_we           = 1'b1;
        cvld_nxt[byte_r] = 1'b1;
        state_nxt        = S_IDLE;
      end
      S_A: begin
        // The arrival memory is read at i this cycle.
        state_nxt = S_B;
      end
      S_B: begin
        sym_nxt   = arr_q;
        cnt_raddr = arr_q;
        state_nxt = S_C;
      end
      S_C: begin
        c_nxt = cnt_eff;
        j_nxt = i_r;
        if (i_r == '0) begin
          srt_we    = 1'b1;
          srt_waddr = '0;
          state_nxt = S_W;
        end else begin
          srt_raddr = i_r - SYM_W'(1);
          state_nxt = S_D;
        end
        if (i_r == '0) begin
          // First symbol goes straight to the head; skip the extra write.
          if (last_sym) begin
            sort_done_nxt = 1'b1;
            state_nxt     = S_EMIT;
          end else begin
            i_nxt     = i_r + SYM_W'(1);
            state_nxt = S_A;
          end
        end
      end
      S_D: begin
        prev_nxt  = srt_q;
        cnt_raddr = srt_q;
        state_nxt = S_E;
      end
      S_E: begin
        srt_we = 1'b1;
        if (cnt_eff > c_r) begin
          // Shift the larger entry up one place and keep walking down.
          srt_wdata = prev_r;
          j_nxt     = j_r - SYM_W'(1);
          if (j_r == SYM_W'(1)) begin
            state_nxt = S_W;
          end else begin
            srt_raddr = j_r - SYM_W'(2);
            state_nxt = S_D;
          end
        end else if (last_sym) begin
          sort_done_nxt = 1'b1;
          state_nxt     = S_EMIT;
        end else begin
          i_nxt     = i_r + SYM_W'(1);
          state_nxt = S_A;
        end
      end
      S_W: begin
        srt_we    = 1'b1;
        srt_waddr = '0;
        if (last_sym) begin
          sort_done_nxt = 1'b1;
          state_nxt     = S_EMIT;
        end else begin
          i_nxt     = i_r + SYM_W'(1);
          state_nxt = S_A;
        end
      end
      S_R1: begin
        sym_nxt   = srt_q;
        cnt_raddr = srt_q;
        state_nxt = S_R2;
      end
      S_R2: begin
        res_sym_nxt  = sym_r;
        res_freq_nxt = cnt_eff;
        res_ev_nxt   = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = 9'(res_dist_r);
          out_sym_nxt   = 8'(res_sym_r);
          out_freq_nxt  = 32'(res_freq_r);
          out_ev_nxt    = res_ev_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cvld_r      <= '0;
      distinct_r  <= '0;
      sort_done_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cvld_r      <= cvld_nxt;
      distinct_r  <= distinct_nxt;
      sort_done_r <= sort_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
    byte_r     <= byte_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    sym_r      <= sym_nxt;
    prev_r     <= prev_nxt;
    c_r        <= c_nxt;
    res_dist_r <= res_dist_nxt;
    res_sym_r  <= res_sym_nxt;
    res_freq_r <= res_freq_nxt;
    res_ev_r   <= res_ev_nxt;
    out_dist_r <= out_dist_nxt;
    out_sym_r  <= out_sym_nxt;
    out_freq_r <= out_freq_nxt;
    out_ev_r   <= out_ev_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_distinct_symbols = out_dist_r;
  assign out_symbol           = out_sym_r;
  assign out_frequency        = out_freq_r;
  assign out_entry_valid      = out_ev_r;

  // The distinct count never passes the table size.
  `BFST_ASSERT_IMPL(a_dist_range, 1'b1, distinct_r <= DIST_W'(SYM_CNT))
  // The compare step never runs with the insertion point at the head.
  `BFST_ASSERT_IMPL(a_walk_nonzero, state_r == S_E, j_r != '0)
  // An in-range count item always goes on to its update cycle.
  `BFST_ASSERT_NEXT(a_count_update,
    accept && (in_action == ACT_COUNT) && (9'(in_byte_value) < 9'(SYM_CNT)),
    state_r == S_CNT)

endmodule

/* tb/tb_byte_frequency_sorted_table.sv */
`timescale 1ns / 100ps

module tb_byte_frequency_sorted_table;
  import bfst_pkg::*;

  // Clock, reset and the ports of the block. Every input starts at a known value.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action = ACT_COUNT;
  logic [7:0]  in_byte_value = 8'd0;
  logic [7:0]  in_rank = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [8:0]  out_distinct_symbols;
  logic [7:0]  out_symbol;
  logic [31:0] out_frequency;
  logic        out_entry_valid;

  byte_frequency_sorted_table i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_byte_value       (in_byte_value),
    .in_rank             (in_rank),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_distinct_symbols(out_distinct_symbols),
    .out_symbol          (out_symbol),
    .out_frequency       (out_frequency),
    .out_entry_valid     (out_entry_valid)
  );

  // A full sort of 256 distinct symbols accepts nothing on either channel while
  // it runs, and the sender may idle on top of that, so the stall limit is generous.
  localparam int STALL_LIMIT = 400000;
  localparam int DRAIN_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1700;

  typedef struct packed {
    logic [8:0]  distinct;
    logic [7:0]  symbol;
    logic [31:0] frequency;
    logic        entry_valid;
  } table_result_t;

  typedef struct packed {
    action_t       act;
    logic [7:0]    byte_value;
    logic [7:0]    rank;
    logic          typed;   // expected result written in the row itself
    table_result_t result;
  } stim_row_t;

  // Shadow copy of the block's state, used to predict every result.
  logic [31:0] shadow_count [SYM_CNT];
  logic [7:0]  shadow_arrival [SYM_CNT];
  logic [7:0]  shadow_sorted [SYM_CNT];
  int unsigned shadow_distinct;
  bit          shadow_sorted_ok;

  table_result_t pending_results[$];
  int unsigned   error_count = 0;
  int unsigned   items_sent = 0;
  int unsigned   sorts_sent = 0;
  int unsigned   reads_sent = 0;
  int unsigned   results_seen = 0;
  int unsigned   stall_cycles = 0;
  int unsigned   sender_idle_pct = 0;
  int unsigned   receiver_idle_pct = 0;
  bit            largest_sort_done = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Insertion sort of the distinct symbols by count. Only strictly larger counts
  // are shifted, so equal counts keep their order of first appearance.
  task automatic shadow_sort();
    int unsigned j;
    logic [7:0]  sym;
    for (int unsigned i = 0; i < shadow_distinct; i++) begin
      sym = shadow_arrival[i];
      j = i;
      while (j > 0 && shadow_count[shadow_sorted[j - 1]] > shadow_count[sym]) begin
        shadow_sorted[j] = shadow_sorted[j - 1];
        j--;
      end
      shadow_sorted[j] = sym;
    end
    shadow_sorted_ok = 1'b1;
  endtask

  // Applies one accepted item to the shadow state. Returns 1 when the item
  // produces a result, which is then placed in res.
  task automatic shadow_apply(input action_t act, input logic [7:0] b, input logic [7:0] r,
                              output bit has_res, output table_result_t res);
    res = '0;
    res.distinct = shadow_distinct[8:0];
    has_res = 1'b0;
    case (act)
      ACT_COUNT: begin
        if (shadow_count[b] == 32'd0 && shadow_distinct < SYM_CNT) begin
          shadow_arrival[shadow_distinct] = b;
          shadow_distinct++;
        end
        if (shadow_count[b] != 32'hFFFF_FFFF) shadow_count[b] = shadow_count[b] + 32'd1;
        shadow_sorted_ok = 1'b0;
      end
      ACT_CLEAR: begin
        for (int i = 0; i < SYM_CNT; i++) shadow_count[i] = 32'd0;
        shadow_distinct = 0;
        shadow_sorted_ok = 1'b0;
      end
      ACT_SORT: begin
        shadow_sort();
        has_res = 1'b1;
      end
      default: begin
        has_res = 1'b1;
        if (shadow_sorted_ok && r < shadow_distinct) begin
          res.symbol = shadow_sorted[r];
          res.frequency = shadow_count[shadow_sorted[r]];
          res.entry_valid = 1'b1;
        end
      end
    endcase
  endtask

  // Idling profile follows the item count: none, sender idle, receiver stalls,
  // then both at a lighter rate.
  task automatic pick_idle_phase();
    case ((items_sent / 150) % 4)
      0: begin sender_idle_pct = 0;  receiver_idle_pct = 0;  end
      1: begin sender_idle_pct = 66; receiver_idle_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_idle_pct = 66; end
      default: begin sender_idle_pct = 22; receiver_idle_pct = 22; end
    endcase
  endtask

  // Drives one item from a falling edge and returns at the falling edge after
  // it was accepted. Valid stays high when items follow back to back.
  task automatic send_item(input action_t act, input logic [7:0] b, input logic [7:0] r,
                           input bit typed, input table_result_t typed_res);
    bit            has_res;
    table_result_t res;
    pick_idle_phase();
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_action = act;
    in_byte_value = b;
    in_rank = r;
    do @(posedge clk); while (!in_ready);
    shadow_apply(act, b, r, has_res, res);
    if (has_res) pending_results.push_back(typed ? typed_res : res);
    items_sent++;
    if (act == ACT_SORT) sorts_sent++;
    if (act == ACT_READ) reads_sent++;
    @(negedge clk);
  endtask

  task automatic send_plain(input action_t act, input logic [7:0] b, input logic [7:0] r);
    send_item(act, b, r, 1'b0, '0);
  endtask

  // The receiver stalls at random according to the current phase.
  always @(negedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // Result checker: each accepted result is compared with the oldest expectation.
  always @(posedge clk) begin
    table_result_t exp_res;
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) stall_cycles <= 0;
    else if (rst_n) stall_cycles <= stall_cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no expectation: distinct_symbols %0d", out_distinct_symbols);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_distinct_symbols !== exp_res.distinct) begin
          $error("distinct_symbols expected %0d got %0d", exp_res.distinct,
                 out_distinct_symbols);
          error_count++;
        end
        if (out_symbol !== exp_res.symbol) begin
          $error("symbol expected %0d got %0d", exp_res.symbol, out_symbol);
          error_count++;
        end
        if (out_frequency !== exp_res.frequency) begin
          $error("frequency expected %0d got %0d", exp_res.frequency, out_frequency);
          error_count++;
        end
        if (out_entry_valid !== exp_res.entry_valid) begin
          $error("entry_valid expected %0d got %0d", exp_res.entry_valid, out_entry_valid);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted item on either channel.
  always @(posedge clk) begin
    if (stall_cycles >= STALL_LIMIT) begin
      $display("stalled for %0d cycles with %0d results pending", stall_cycles,
               pending_results.size());
      $display("[byte_frequency_sorted_table] ERROR");
      $finish;
    end
  end

  // Directed part: reads before any sort, the empty sort, the byte extremes,
  // ties resolved by first appearance, ranks out of range, a stale sort and clear.
  localparam int DIRECTED_ROWS = 22;
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ACT_READ,  8'd0,   8'd0,   1'b1, '{9'd0, 8'd0,   32'd0, 1'b0}},
    '{ACT_SORT,  8'd0,   8'd0,   1'b1, '{9'd0, 8'd0,   32'd0, 1'b0}},
    '{ACT_READ,  8'd0,   8'd0,   1'b1, '{9'd0, 8'd0,   32'd0, 1'b0}},
    '{ACT_COUNT, 8'd0,   8'd0,   1'b0, '0},
    '{ACT_COUNT, 8'd255, 8'd0,   1'b0, '0},
    '{ACT_COUNT, 8'd255, 8'd0,   1'b0, '0},
    '{ACT_READ,  8'd0,   8'd0,   1'b1, '{9'd2, 8'd0,   32'd0, 1'b0}},
    '{ACT_SORT,  8'd0,   8'd0,   1'b1, '{9'd2, 8'd0,   32'd0, 1'b0}},
    '{ACT_READ,  8'd0,   8'd0,   1'b1, '{9'd2, 8'd0,   32'd1, 1'b1}},
    '{ACT_READ,  8'd0,   8'd1,   1'b1, '{9'd2, 8'd255, 32'd2, 1'b1}},
    '{ACT_READ,  8'd0,   8'd2,   1'b1, '{9'd2, 8'd0,   32'd0, 1'b0}},
    '{ACT_READ,  8'd0,   8'd255, 1'b1, '{9'd2, 8'd0,   32'd0, 1'b0}},
    '{ACT_COUNT, 8'd170, 8'd0,   1'b0, '0},
    '{ACT_COUNT, 8'd85,  8'd0,   1'b0, '0},
    '{ACT_READ,  8'd0,   8'd0,   1'b1, '{9'd4, 8'd0,   32'd0, 1'b0}},
    '{ACT_SORT,  8'd0,   8'd0,   1'b0, '0},
    '{ACT_READ,  8'd0,   8'd0,   1'b0, '0},
    '{ACT_READ,  8'd0,   8'd1,   1'b0, '0},
    '{ACT_READ,  8'd0,   8'd3,   1'b0, '0},
    '{ACT_CLEAR, 8'd0,   8'd0,   1'b0, '0},
    '{ACT_READ,  8'd0,   8'd0,   1'b1, '{9'd0, 8'd0,   32'd0, 1'b0}},
    '{ACT_SORT,  8'd0,   8'd0,   1'b1, '{9'd0, 8'd0,   32'd0, 1'b0}}
  };

  // Main stimulus. Random traffic is mostly well-formed runs: an optional
  // clear, a burst of counts over a small alphabet, a sort and some reads.
  // One run fills all 256 symbols to exercise the largest sort.
  initial begin
    int unsigned n_counts;
    int unsigned alphabet;
    int unsigned n_reads;
    int unsigned stride;
    int unsigned drain;
    logic [7:0]  base;
    logic [7:0]  r;

    for (int i = 0; i < SYM_CNT; i++) begin
      shadow_count[i] = 32'd0;
      shadow_arrival[i] = 8'd0;
      shadow_sorted[i] = 8'd0;
    end
    shadow_distinct = 0;
    shadow_sorted_ok = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[k]) begin
      send_item(directed_rows[k].act, directed_rows[k].byte_value, directed_rows[k].rank,
                directed_rows[k].typed, directed_rows[k].result);
    end

    while (items_sent < RANDOM_ITEMS) begin
      if (!largest_sort_done && items_sent > 800) begin
        largest_sort_done = 1'b1;
        send_plain(ACT_CLEAR, 8'($urandom), 8'($urandom));
        stride = 2 * $urandom_range(0, 127) + 1;
        base = 8'($urandom);
        for (int unsigned i = 0; i < SYM_CNT; i++) begin
          send_plain(ACT_COUNT, 8'(base + i * stride), 8'($urandom));
          if ($urandom_range(3) == 0) send_plain(ACT_COUNT, 8'($urandom), 8'($urandom));
        end
        send_plain(ACT_SORT, 8'($urandom), 8'($urandom));
        send_plain(ACT_READ, 8'($urandom), 8'd0);
        send_plain(ACT_READ, 8'($urandom), 8'd255);
        for (int i = 0; i < 6; i++) send_plain(ACT_READ, 8'($urandom), 8'($urandom));
        send_plain(ACT_CLEAR, 8'($urandom), 8'($urandom));
      end else if ($urandom_range(99) < 75) begin
        // Keep the table small so that most sorts stay short.
        if (shadow_distinct > 48 || $urandom_range(1) == 0)
          send_plain(ACT_CLEAR, 8'($urandom), 8'($urandom));
        n_counts = $urandom_range(1, 40);
        alphabet = $urandom_range(1, 12);
        base = 8'($urandom);
        for (int unsigned i = 0; i < n_counts; i++)
          send_plain(ACT_COUNT, 8'(base + $urandom_range(alphabet - 1)), 8'($urandom));
        send_plain(ACT_SORT, 8'($urandom), 8'($urandom));
        n_reads = $urandom_range(1, 6);
        for (int unsigned i = 0; i < n_reads; i++) begin
          if ($urandom_range(4) == 0) r = 8'($urandom);
          else r = 8'($urandom_range(0, shadow_distinct));
          send_plain(ACT_READ, 8'($urandom), r);
        end
      end else begin
        // Noise: a lone item of any kind, which may leave the sort stale.
        if (shadow_distinct > 64) send_plain(ACT_CLEAR, 8'($urandom), 8'($urandom));
        send_plain(action_t'($urandom_range(3)), 8'($urandom), 8'($urandom));
      end
    end

    in_valid = 1'b0;
    drain = 0;
    while (pending_results.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    if (pending_results.size() != 0) begin
      $display("%0d results never arrived", pending_results.size());
      $display("[byte_frequency_sorted_table] ERROR");
      $finish;
    end else begin
      repeat (20) @(posedge clk);
      $display("Covered %0d items (%0d sorts, %0d reads), %0d results checked,",
               items_sent, sorts_sent, reads_sent, results_seen);
      $display("including a full 256-symbol sort and all four idling profiles.");
      if (error_count == 0 && pending_results.size() == 0) begin
        $display("[byte_frequency_sorted_table] OK");
      end else begin
        $display("[byte_frequency_sorted_table] ERROR");
      end
      $finish;
    end
  end

endmodule
